>>> rtl/core/srsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sound generator package
// Shared types and constants for the shift register sound generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_W    = 24;
  localparam int unsigned SAMPLE_W = 14;
  localparam int unsigned VOL_W    = 4;
  localparam int unsigned VOL_SHIFT = 10;

  localparam logic [1:0] REG_SOUND_ENABLE = 2'd0;
  localparam logic [1:0] REG_FAST_RATE    = 2'd1;
  localparam logic [1:0] REG_NOISE_MODE   = 2'd2;
  localparam logic [1:0] REG_VOLUME       = 2'd3;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic [1:0] SEL_LOW  = 2'd0;
  localparam logic [1:0] SEL_MID  = 2'd1;
  localparam logic [1:0] SEL_HIGH = 2'd2;

  localparam logic [2:0] PERIOD_FAST = 3'd1;
  localparam logic [2:0] PERIOD_SLOW = 3'd4;

  typedef struct packed {
    logic             sound_enable;
    logic             fast_rate;
    logic             noise_mode;
    logic [VOL_W-1:0] volume;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [1:0] byte_select;
    logic [7:0] load_value;
  } item_t;

endpackage : srsg_pkg
`default_nettype wire

>>> rtl/core/shift_register_sound_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift register sound generator
// Top level: input register, shifter core, output register and APB registers.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle while in_stall_o is low and
// returns a sample beat for every tick, with no beat for a load. The rate is
// set by the single pass through the shifter core between the input and
// output registers; in_stall_o rises only when a tick waits in the input
// register behind a sample that the consumer is stalling. Registers sit at
// byte addresses 0 (sound enable), 4 (fast rate), 8 (noise mode) and 12
// (volume); the user must write them only while the block is idle; unenforced.
module shift_register_sound_generator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srsg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [srsg_pkg::DATA_W-1:0]   pwdata,
  output logic      [srsg_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [1:0]                    byte_select_i,
  input  wire logic [7:0]                    load_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [srsg_pkg::SAMPLE_W-1:0] sample_o
);
  import srsg_pkg::*;

  cfg_t                cfg;
  item_t               item_q;
  logic                busy_q;
  logic                busy_d;
  logic                in_fire;
  logic                step;
  logic                has_result;
  logic                out_free;
  logic [SAMPLE_W-1:0] sample_next;

  srsg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign step       = busy_q && (!has_result || out_free);
  assign in_stall_o = busy_q && !step;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign busy_d     = in_fire || (busy_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{action: action_i, byte_select: byte_select_i, load_value: load_value_i};
    end
  end

  srsg_shifter u_shifter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .sample_o     (sample_next)
  );

  srsg_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && has_result),
    .sample_i    (sample_next),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .sample_o    (sample_o)
  );

endmodule : shift_register_sound_generator_top
`default_nettype wire

>>> rtl/core/srsg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding enable, rate, noise and volume settings.
// ----------------------------------------------------------------------------
module srsg_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srsg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [srsg_pkg::DATA_W-1:0] pwdata,
  output logic      [srsg_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output srsg_pkg::cfg_t                   cfg_o
);
  import srsg_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SOUND_ENABLE: cfg_d.sound_enable = pwdata[0];
        REG_FAST_RATE:    cfg_d.fast_rate    = pwdata[0];
        REG_NOISE_MODE:   cfg_d.noise_mode   = pwdata[0];
        REG_VOLUME:       cfg_d.volume       = pwdata[VOL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SOUND_ENABLE: prdata[0] = cfg_q.sound_enable;
      REG_FAST_RATE:    prdata[0] = cfg_q.fast_rate;
      REG_NOISE_MODE:   prdata[0] = cfg_q.noise_mode;
      REG_VOLUME:       prdata[VOL_W-1:0] = cfg_q.volume;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : srsg_cfg
`default_nettype wire

>>> rtl/core/srsg_shifter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shifter core
// Holds the 24-bit shift register and divide counter and computes one sample.
// ----------------------------------------------------------------------------
module srsg_shifter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  srsg_pkg::item_t                    item_i,
  input  srsg_pkg::cfg_t                     cfg_i,
  output logic                               has_result_o,
  output logic      [srsg_pkg::SAMPLE_W-1:0] sample_o
);
  import srsg_pkg::*;

  logic [REG_W-1:0] shreg_q;
  logic [REG_W-1:0] shreg_d;
  logic [1:0]       div_q;
  logic [1:0]       div_d;
  logic [REG_W-1:0] advanced;
  logic [2:0]       cnt;
  logic [2:0]       period;
  logic             fb;

  always_comb begin
    fb = shreg_q[0] ^ shreg_q[5];
    if (cfg_i.noise_mode) begin
      advanced = {shreg_q[23] | fb, shreg_q[22:16], fb, shreg_q[15:1]};
    end else begin
      advanced = {shreg_q[0], shreg_q[23:1]};
    end
  end

  assign cnt    = {1'b0, div_q} + 3'd1;
  assign period = cfg_i.fast_rate ? PERIOD_FAST : PERIOD_SLOW;

  always_comb begin
    shreg_d      = shreg_q;
    div_d        = div_q;
    has_result_o = 1'b0;
    sample_o     = '0;
    if (item_i.action == ACT_LOAD) begin
      case (item_i.byte_select)
        SEL_LOW:  shreg_d[7:0]   = item_i.load_value;
        SEL_MID:  shreg_d[15:8]  = item_i.load_value;
        SEL_HIGH: shreg_d[23:16] = item_i.load_value;
        default:  shreg_d = shreg_q;
      endcase
    end else begin
      has_result_o = 1'b1;
      if (cfg_i.sound_enable) begin
        if (shreg_q[0]) begin
          sample_o = {cfg_i.volume, {VOL_SHIFT{1'b0}}};
        end
        if (cnt >= period) begin
          div_d   = '0;
          shreg_d = advanced;
        end else begin
          div_d = cnt[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shreg_q <= '0;
      div_q   <= '0;
    end else if (step_i) begin
      shreg_q <= shreg_d;
      div_q   <= div_d;
    end
  end

endmodule : srsg_shifter
`default_nettype wire

>>> rtl/core/srsg_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a sample beat until the consumer takes it.
// ----------------------------------------------------------------------------
module srsg_out_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic [srsg_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                          out_stall_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  output logic      [srsg_pkg::SAMPLE_W-1:0] sample_o
);
  import srsg_pkg::*;

  logic                valid_q;
  logic                valid_d;
  logic [SAMPLE_W-1:0] sample_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_i;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

endmodule : srsg_out_stage
`default_nettype wire

>>> rtl/core/srsg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sound generator checker
// Port-level assertions for the shift register sound generator.
// ----------------------------------------------------------------------------
module srsg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          pready,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [srsg_pkg::SAMPLE_W-1:0] sample_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("Stalled sample beat changed or vanished.");

  a_sample_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o[9:0] == 10'd0)
    else $error("Sample is not a multiple of 1024.");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the output side is free.");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("Sample beat appeared without a beat accepted two cycles earlier.");

  a_pready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("Register port inserted a wait state.");

endmodule : srsg_checker

bind shift_register_sound_generator_top srsg_checker u_srsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_o    (sample_o)
);
`default_nettype wire
